// File: rtl/fcce_pkg.sv
// Shared types and constants for the FAT cluster chain engine.
// Used by fcce_ctrl, fcce_datapath and the top level; no dependencies.
package fcce_pkg;

  localparam int unsigned CFG_W = 13;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned VAL_W = 32;

  localparam logic [VAL_W-1:0] EOC_MIN  = 32'h0FFF_FFF8;
  localparam logic [VAL_W-1:0] EOC_MARK = 32'h0FFF_FFFF;

  typedef logic [2:0] action_t;
  localparam action_t ACT_READ   = 3'd0;
  localparam action_t ACT_WRITE  = 3'd1;
  localparam action_t ACT_NEXT   = 3'd2;
  localparam action_t ACT_ALLOC  = 3'd3;
  localparam action_t ACT_EXTEND = 3'd4;
  localparam action_t ACT_FREE   = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOSPACE = 2'd1;
  localparam status_t ST_RANGE   = 2'd2;

  typedef logic [4:0] op_t;
  localparam op_t OP_NONE     = 5'd0;
  localparam op_t OP_LOAD     = 5'd1;
  localparam op_t OP_CLR      = 5'd2;
  localparam op_t OP_WR_IDX   = 5'd3;
  localparam op_t OP_RD_CUR   = 5'd4;
  localparam op_t OP_RD_CAND  = 5'd5;
  localparam op_t OP_RES_RAW  = 5'd6;
  localparam op_t OP_RES_NEXT = 5'd7;
  localparam op_t OP_ERR      = 5'd8;
  localparam op_t OP_NOSPC    = 5'd9;
  localparam op_t OP_AL_FOUND = 5'd10;
  localparam op_t OP_AP_TAKE  = 5'd11;
  localparam op_t OP_AP_SKIP  = 5'd12;
  localparam op_t OP_AP_END   = 5'd13;
  localparam op_t OP_WK_STEP  = 5'd14;
  localparam op_t OP_WK_END   = 5'd15;
  localparam op_t OP_FR_STEP  = 5'd16;
  localparam op_t OP_FR_RANGE = 5'd17;
  localparam op_t OP_EMIT     = 5'd18;

  typedef struct packed {
    action_t act;
    logic    idx_bad;
    logic    clr_last;
    logic    cand_ge_lim;
    logic    got_ge_n;
    logic    rd_zero;
    logic    rd_end;
    logic    rd_ge_lim;
    logic    steps_hit;
  } dp_status_t;

endpackage

// File: rtl/fcce_datapath.sv
// Datapath of the FAT cluster chain engine: cluster table memory, walk and
// scan registers, result registers. Driven by op codes from fcce_ctrl; uses fcce_pkg.
module fcce_datapath #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fcce_pkg::op_t                op,
  input  logic [2:0]                   in_action,
  input  logic [fcce_pkg::IDX_W-1:0]   in_index,
  input  logic [fcce_pkg::IDX_W-1:0]   in_count,
  input  logic [fcce_pkg::VAL_W-1:0]   in_value,
  input  logic [fcce_pkg::CFG_W-1:0]   cfg_clusters,
  output fcce_pkg::dp_status_t         status,
  output logic [fcce_pkg::VAL_W-1:0]   out_result,
  output logic [fcce_pkg::CFG_W-1:0]   out_done,
  output fcce_pkg::status_t            out_status
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned LW = (AW + 1 > fcce_pkg::CFG_W) ? AW + 1 : fcce_pkg::CFG_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  logic [fcce_pkg::VAL_W-1:0] mem [TABLE_DEPTH];
  logic [fcce_pkg::VAL_W-1:0] rdata;

  fcce_pkg::action_t          act;
  logic [fcce_pkg::IDX_W-1:0] idx_l;
  logic [fcce_pkg::IDX_W-1:0] cnt_l;
  logic [fcce_pkg::VAL_W-1:0] val_l;
  logic [LW-1:0]              lim;
  logic [AW-1:0]              cur;
  logic [AW-1:0]              first;
  logic [LW-1:0]              cand;
  logic [LW-1:0]              got;
  logic [LW-1:0]              n;
  logic [LW-1:0]              steps;
  logic [fcce_pkg::VAL_W-1:0] res;
  logic [LW-1:0]              done;
  fcce_pkg::status_t          st;
  logic [AW-1:0]              clr;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [fcce_pkg::VAL_W-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;

  logic [LW-1:0] cfg_ext;
  logic [LW-1:0] idx_ext;
  logic [LW-1:0] cnt_ext;
  logic [LW-1:0] steps_inc;

  assign cfg_ext   = LW'(cfg_clusters);
  assign idx_ext   = LW'(idx_l);
  assign cnt_ext   = LW'(cnt_l);
  assign steps_inc = steps + 1'b1;

  assign status.act         = act;
  assign status.idx_bad     = idx_ext >= lim;
  assign status.clr_last    = clr == LAST_ADDR;
  assign status.cand_ge_lim = cand >= lim;
  assign status.got_ge_n    = got >= n;
  assign status.rd_zero     = rdata == '0;
  assign status.rd_end      = rdata >= fcce_pkg::EOC_MIN;
  assign status.rd_ge_lim   = rdata >= fcce_pkg::VAL_W'(lim);
  assign status.steps_hit   = steps_inc >= lim;

  // memory port decode
  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = '0;
    re    = 1'b0;
    raddr = cur;
    case (op)
      fcce_pkg::OP_CLR: begin
        we    = 1'b1;
        waddr = clr;
      end
      fcce_pkg::OP_WR_IDX: begin
        we    = 1'b1;
        waddr = idx_ext[AW-1:0];
        wdata = val_l;
      end
      fcce_pkg::OP_RD_CUR: begin
        re = 1'b1;
      end
      fcce_pkg::OP_RD_CAND: begin
        re    = 1'b1;
        raddr = cand[AW-1:0];
      end
      fcce_pkg::OP_AL_FOUND: begin
        we    = 1'b1;
        waddr = cand[AW-1:0];
        wdata = fcce_pkg::EOC_MARK;
      end
      fcce_pkg::OP_AP_TAKE: begin
        we    = 1'b1;
        wdata = fcce_pkg::VAL_W'(cand);
      end
      fcce_pkg::OP_AP_END: begin
        we    = 1'b1;
        wdata = fcce_pkg::EOC_MARK;
      end
      fcce_pkg::OP_FR_STEP, fcce_pkg::OP_FR_RANGE: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else begin
      case (op)
        fcce_pkg::OP_CLR: begin
          clr <= (clr == LAST_ADDR) ? '0 : clr + 1'b1;
        end
        fcce_pkg::OP_LOAD: begin
          act   <= in_action;
          idx_l <= in_index;
          cnt_l <= in_count;
          val_l <= in_value;
          cur   <= AW'(in_index);
          lim   <= (cfg_ext < DEPTH_L) ? cfg_ext : DEPTH_L;
          cand  <= LW'(2);
          got   <= '0;
          steps <= '0;
          res   <= '0;
          done  <= '0;
          st    <= fcce_pkg::ST_OK;
        end
        fcce_pkg::OP_WR_IDX: begin
          res <= val_l;
        end
        fcce_pkg::OP_RD_CUR: begin
        end
        fcce_pkg::OP_RES_RAW: begin
          res <= rdata;
        end
        fcce_pkg::OP_RES_NEXT: begin
          res <= (rdata >= fcce_pkg::EOC_MIN) ? fcce_pkg::EOC_MARK : rdata;
        end
        fcce_pkg::OP_ERR: begin
          res  <= '0;
          done <= '0;
          st   <= fcce_pkg::ST_RANGE;
        end
        fcce_pkg::OP_NOSPC: begin
          st <= fcce_pkg::ST_NOSPACE;
        end
        fcce_pkg::OP_AL_FOUND: begin
          cur   <= cand[AW-1:0];
          first <= cand[AW-1:0];
          cand  <= cand + 1'b1;
          n     <= (cnt_ext > LW'(1)) ? cnt_ext - 1'b1 : '0;
        end
        fcce_pkg::OP_AP_TAKE: begin
          cur  <= cand[AW-1:0];
          got  <= got + 1'b1;
          cand <= cand + 1'b1;
        end
        fcce_pkg::OP_AP_SKIP: begin
          cand <= cand + 1'b1;
        end
        fcce_pkg::OP_AP_END: begin
          if (act == fcce_pkg::ACT_ALLOC) begin
            res  <= fcce_pkg::VAL_W'(first);
            done <= got + 1'b1;
          end else begin
            res  <= fcce_pkg::VAL_W'(cur);
            done <= got;
          end
          st <= (got < n) ? fcce_pkg::ST_NOSPACE : fcce_pkg::ST_OK;
        end
        fcce_pkg::OP_WK_STEP: begin
          cur   <= rdata[AW-1:0];
          steps <= steps_inc;
        end
        fcce_pkg::OP_WK_END: begin
          cand <= LW'(2);
          n    <= cnt_ext;
        end
        fcce_pkg::OP_FR_STEP: begin
          if (rdata != '0) begin
            done <= done + 1'b1;
          end
          cur <= rdata[AW-1:0];
        end
        fcce_pkg::OP_FR_RANGE: begin
          done <= done + 1'b1;
          st   <= fcce_pkg::ST_RANGE;
        end
        fcce_pkg::OP_EMIT: begin
          out_result <= res;
          out_done   <= done[fcce_pkg::CFG_W-1:0];
          out_status <= st;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/fcce_ctrl.sv
// Controller of the FAT cluster chain engine: sequences table clear, commands,
// walks and scans by issuing op codes to fcce_datapath; uses fcce_pkg.
module fcce_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  fcce_pkg::dp_status_t status,
  output fcce_pkg::op_t        op
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_RDRES = 4'd3;
  localparam logic [3:0] S_AL_RD = 4'd4;
  localparam logic [3:0] S_AL_CK = 4'd5;
  localparam logic [3:0] S_AP_RD = 4'd6;
  localparam logic [3:0] S_AP_CK = 4'd7;
  localparam logic [3:0] S_WK_RD = 4'd8;
  localparam logic [3:0] S_WK_CK = 4'd9;
  localparam logic [3:0] S_FR_RD = 4'd10;
  localparam logic [3:0] S_FR_CK = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    op         = fcce_pkg::OP_NONE;
    case (state)
      S_CLEAR: begin
        op = fcce_pkg::OP_CLR;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op         = fcce_pkg::OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (status.act > fcce_pkg::ACT_FREE ||
            (status.act != fcce_pkg::ACT_ALLOC && status.idx_bad)) begin
          op         = fcce_pkg::OP_ERR;
          state_next = S_OUT;
        end else begin
          case (status.act)
            fcce_pkg::ACT_READ, fcce_pkg::ACT_NEXT: begin
              op         = fcce_pkg::OP_RD_CUR;
              state_next = S_RDRES;
            end
            fcce_pkg::ACT_WRITE: begin
              op         = fcce_pkg::OP_WR_IDX;
              state_next = S_OUT;
            end
            fcce_pkg::ACT_ALLOC: begin
              state_next = S_AL_RD;
            end
            fcce_pkg::ACT_EXTEND: begin
              op         = fcce_pkg::OP_RD_CUR;
              state_next = S_WK_CK;
            end
            default: begin
              op         = fcce_pkg::OP_RD_CUR;
              state_next = S_FR_CK;
            end
          endcase
        end
      end
      S_RDRES: begin
        op = (status.act == fcce_pkg::ACT_NEXT) ? fcce_pkg::OP_RES_NEXT
                                                : fcce_pkg::OP_RES_RAW;
        state_next = S_OUT;
      end
      S_AL_RD: begin
        if (status.cand_ge_lim) begin
          op         = fcce_pkg::OP_NOSPC;
          state_next = S_OUT;
        end else begin
          op         = fcce_pkg::OP_RD_CAND;
          state_next = S_AL_CK;
        end
      end
      S_AL_CK: begin
        if (status.rd_zero) begin
          op         = fcce_pkg::OP_AL_FOUND;
          state_next = S_AP_RD;
        end else begin
          op         = fcce_pkg::OP_AP_SKIP;
          state_next = S_AL_RD;
        end
      end
      S_AP_RD: begin
        if (status.cand_ge_lim || status.got_ge_n) begin
          op         = fcce_pkg::OP_AP_END;
          state_next = S_OUT;
        end else begin
          op         = fcce_pkg::OP_RD_CAND;
          state_next = S_AP_CK;
        end
      end
      S_AP_CK: begin
        op         = status.rd_zero ? fcce_pkg::OP_AP_TAKE : fcce_pkg::OP_AP_SKIP;
        state_next = S_AP_RD;
      end
      S_WK_RD: begin
        op         = fcce_pkg::OP_RD_CUR;
        state_next = S_WK_CK;
      end
      S_WK_CK: begin
        if (status.rd_end) begin
          op         = fcce_pkg::OP_WK_END;
          state_next = S_AP_RD;
        end else if (status.rd_ge_lim || status.steps_hit) begin
          op         = fcce_pkg::OP_ERR;
          state_next = S_OUT;
        end else begin
          op         = fcce_pkg::OP_WK_STEP;
          state_next = S_WK_RD;
        end
      end
      S_FR_RD: begin
        op         = fcce_pkg::OP_RD_CUR;
        state_next = S_FR_CK;
      end
      S_FR_CK: begin
        if (status.rd_zero || status.rd_end) begin
          op         = fcce_pkg::OP_FR_STEP;
          state_next = S_OUT;
        end else if (status.rd_ge_lim) begin
          op         = fcce_pkg::OP_FR_RANGE;
          state_next = S_OUT;
        end else begin
          op         = fcce_pkg::OP_FR_STEP;
          state_next = S_FR_RD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          op         = fcce_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == fcce_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/fat_cluster_chain_engine.sv
// Top level of the FAT cluster chain engine: stream ports, APB register, and
// the fcce_ctrl / fcce_datapath pair; uses fcce_pkg.
// Accept to result beat: read/next pass dispatch, a table read and a result step; write and
// dispatch errors go straight to output; allocate, extend and free read and check each entry visited.
// One command at a time: input ready returns with the result beat, which waits in its register.
// Reset clears the table in a pass over every entry; no command is taken until then.
module fat_cluster_chain_engine #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] action, [14:3] cluster_index, [26:15] request_count, [58:27] entry_value
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] result_cluster, [44:32] clusters_done, [46:45] status
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [fcce_pkg::CFG_W-1:0] clusters_in_use;
  fcce_pkg::op_t              op;
  fcce_pkg::dp_status_t       dp_status;
  logic [fcce_pkg::VAL_W-1:0] out_result;
  logic [fcce_pkg::CFG_W-1:0] out_done;
  fcce_pkg::status_t          out_status;

  // register file: only clusters_in_use, in the word at byte address zero
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(clusters_in_use) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_in_use <= 13'd4096;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      clusters_in_use <= pwdata[fcce_pkg::CFG_W-1:0];
    end
  end

  fcce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (dp_status),
    .op        (op)
  );

  fcce_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .in_action    (s_axis_tdata[2:0]),
    .in_index     (s_axis_tdata[14:3]),
    .in_count     (s_axis_tdata[26:15]),
    .in_value     (s_axis_tdata[58:27]),
    .cfg_clusters (clusters_in_use),
    .status       (dp_status),
    .out_result   (out_result),
    .out_done     (out_done),
    .out_status   (out_status)
  );

  assign m_axis_tdata = {1'b0, out_status, out_done, out_result};

endmodule

// File: rtl/fcce_checker.sv
// Port-level checks for fat_cluster_chain_engine, bound to the top level.
// Depends only on the top level's ports.
module fcce_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[46:45] != 2'd3)
    else $error("undefined status code");

  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("command taken during table clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while one is in flight");

endmodule

bind fat_cluster_chain_engine fcce_checker u_fcce_checker (.*);

// File: bench/fat_cluster_chain_engine_tb.sv
// Self-checking testbench for fat_cluster_chain_engine: drives commands on the
// input stream, sets clusters_in_use over APB and checks every result beat
// against a cycle-free model of the cluster table. Depends on rtl/fcce_pkg.sv and the top level.
module fat_cluster_chain_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 4096;
  localparam int unsigned STALL_LIMIT = 200000;

  typedef struct {
    logic [31:0]       cluster;
    logic [12:0]       done;
    fcce_pkg::status_t st;
  } fat_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [47:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fat_cluster_chain_engine #(.TABLE_DEPTH(DEPTH)) uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model state: the cluster table and the active cluster count.
  logic [31:0] fat_mem [DEPTH];
  logic [12:0] clusters_cfg;
  fat_result_t pending_results[$];
  int          chain_heads[$];

  int  mismatches = 0;
  int  cmds_sent = 0;
  int  results_seen = 0;
  int  action_hits[8];
  int  nospace_seen = 0;
  int  range_seen = 0;
  bit  steady = 1'b0;   // when set, neither side idles

  function automatic int unsigned active_limit();
    return (clusters_cfg < DEPTH) ? int'(clusters_cfg) : DEPTH;
  endfunction

  // Link up to n free clusters behind end cluster tail; return the new tail.
  function automatic int unsigned link_free(int unsigned tail, int unsigned n,
                                            int unsigned lim, output int unsigned got);
    int unsigned cur;
    cur = tail;
    got = 0;
    for (int unsigned cand = 2; cand < lim && got < n; cand++) begin
      if (fat_mem[cand] != 0) continue;
      fat_mem[cur] = cand;
      cur = cand;
      got++;
    end
    fat_mem[cur] = fcce_pkg::EOC_MARK;
    return cur;
  endfunction

  // Apply one command to the model table and return its result.
  function automatic fat_result_t run_fat_command(fcce_pkg::action_t act, logic [11:0] idx,
                                                   logic [11:0] cnt, logic [31:0] val);
    fat_result_t r;
    int unsigned lim, cur, got, want, first, steps;
    logic [31:0] v;
    bit bad;
    lim = active_limit();
    r.cluster = '0;
    r.done = '0;
    r.st = fcce_pkg::ST_OK;
    got = 0;
    if (act > fcce_pkg::ACT_FREE) begin
      r.st = fcce_pkg::ST_RANGE;
    end else if (act != fcce_pkg::ACT_ALLOC && idx >= lim) begin
      r.st = fcce_pkg::ST_RANGE;
    end else begin
      case (act)
        fcce_pkg::ACT_READ: r.cluster = fat_mem[idx];
        fcce_pkg::ACT_WRITE: begin
          fat_mem[idx] = val;
          r.cluster = val;
        end
        fcce_pkg::ACT_NEXT:
          r.cluster = (fat_mem[idx] >= fcce_pkg::EOC_MIN) ? fcce_pkg::EOC_MARK : fat_mem[idx];
        fcce_pkg::ACT_ALLOC: begin
          for (first = 2; first < lim; first++)
            if (fat_mem[first] == 0) break;
          if (first >= lim) begin
            r.st = fcce_pkg::ST_NOSPACE;
          end else begin
            want = (cnt > 1) ? cnt - 1 : 0;
            fat_mem[first] = fcce_pkg::EOC_MARK;
            if (want > 0) void'(link_free(first, want, lim, got));
            r.cluster = first;
            r.done = 13'(1 + got);
            if (got < want) r.st = fcce_pkg::ST_NOSPACE;
          end
        end
        fcce_pkg::ACT_EXTEND: begin
          cur = 32'(idx);
          steps = 0;
          bad = 1'b0;
          while (fat_mem[cur] < fcce_pkg::EOC_MIN) begin
            v = fat_mem[cur];
            steps++;
            if (v >= lim || steps >= lim) begin
              bad = 1'b1;
              break;
            end
            cur = v;
          end
          if (bad) begin
            r.st = fcce_pkg::ST_RANGE;
          end else begin
            r.cluster = link_free(cur, 32'(cnt), lim, got);
            r.done = 13'(got);
            if (got < cnt) r.st = fcce_pkg::ST_NOSPACE;
          end
        end
        default: begin
          // free: clear until an end mark, a free entry or a link out of range
          cur = 32'(idx);
          forever begin
            v = fat_mem[cur];
            fat_mem[cur] = 0;
            if (v == 0) break;
            r.done++;
            if (v >= fcce_pkg::EOC_MIN) break;
            if (v >= lim) begin
              r.st = fcce_pkg::ST_RANGE;
              break;
            end
            cur = v;
          end
        end
      endcase
    end
    return r;
  endfunction

  // Send one command beat; predict its result at the accepting edge.
  task automatic send_cmd(fcce_pkg::action_t act, logic [11:0] idx, logic [11:0] cnt,
                          logic [31:0] val);
    int gap;
    fat_result_t r;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, val, cnt, idx, act};
    // sample ready mid-cycle so the accepting edge is known without a race
    forever begin
      @(negedge clk);
      if (s_axis_tready) break;
    end
    @(posedge clk);
    r = run_fat_command(act, idx, cnt, val);
    pending_results.push_back(r);
    cmds_sent++;
    action_hits[act]++;
    if (r.st == fcce_pkg::ST_NOSPACE) nospace_seen++;
    if (r.st == fcce_pkg::ST_RANGE) range_seen++;
    if (act == fcce_pkg::ACT_ALLOC && r.done != 0) chain_heads.push_back(int'(r.cluster));
  endtask

  // Hold off until every expected result has arrived, then let the block settle.
  task automatic drain_results();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cluster_count(logic [12:0] value);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {19'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    clusters_cfg = value;
    chain_heads.delete();
  endtask

  // Output side: sample the handshake mid-cycle, act on it at the next edge.
  logic        out_beat = 1'b0;
  logic        in_beat = 1'b0;
  logic [47:0] out_word;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  always @(negedge clk) begin
    out_beat <= m_axis_tvalid && m_axis_tready && !rst;
    in_beat <= s_axis_tvalid && s_axis_tready && !rst;
    out_word <= m_axis_tdata;
  end

  always @(posedge clk) begin
    fat_result_t want;
    int draw;
    if (out_beat) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat %h", $realtime, out_word);
      end else begin
        want = pending_results.pop_front();
        if (out_word[31:0] !== want.cluster || out_word[44:32] !== want.done ||
            out_word[46:45] !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch: cluster %h/%h done %0d/%0d status %0d/%0d",
                     $realtime, want.cluster, out_word[31:0], want.done,
                     out_word[44:32], want.st, out_word[46:45]);
        end
      end
      // draw the receiver's stall for the next beat
      draw = steady ? 0 : $urandom_range(0, 7);
      if (draw != 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= draw;
      end
    end else if (!m_axis_tready) begin
      if (stall_left <= 1) m_axis_tready <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog: count edges with no beat on either side.
  always @(posedge clk) begin
    if (out_beat || in_beat) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Extremes of every field and each corner of the command set, default count.
  task automatic test_directed();
    send_cmd(fcce_pkg::ACT_READ, 12'd0, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_WRITE, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    send_cmd(fcce_pkg::ACT_READ, 12'hFFF, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_NEXT, 12'hFFF, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_FREE, 12'hFFF, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_ALLOC, 12'd0, 12'd0, 32'd0);      // zero count takes one
    send_cmd(fcce_pkg::ACT_ALLOC, 12'd0, 12'd1, 32'd0);
    send_cmd(fcce_pkg::ACT_ALLOC, 12'd77, 12'd5, 32'd0);
    send_cmd(fcce_pkg::ACT_NEXT, 12'd4, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_EXTEND, 12'd2, 12'd0, 32'd0);     // zero count rewrites the end
    send_cmd(fcce_pkg::ACT_EXTEND, 12'd4, 12'd3, 32'd0);
    send_cmd(fcce_pkg::ACT_FREE, 12'd4, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_FREE, 12'd4, 12'd0, 32'd0);       // already free
    send_cmd(3'd6, 12'd1, 12'd1, 32'd1);
    send_cmd(3'd7, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    send_cmd(fcce_pkg::ACT_WRITE, 12'd20, 12'd0, 32'd21);    // chain into a free entry
    send_cmd(fcce_pkg::ACT_FREE, 12'd20, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_WRITE, 12'd30, 12'd0, fcce_pkg::EOC_MIN);
    send_cmd(fcce_pkg::ACT_NEXT, 12'd30, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_EXTEND, 12'd30, 12'd2, 32'd0);
    send_cmd(fcce_pkg::ACT_WRITE, 12'd31, 12'd0, 32'h0FFF_FFF7);
    send_cmd(fcce_pkg::ACT_NEXT, 12'd31, 12'd0, 32'd0);
  endtask

  // Small tables: running out of space, out-of-range indexes, broken chains.
  task automatic test_small_tables();
    write_cluster_count(13'd3);
    send_cmd(fcce_pkg::ACT_ALLOC, 12'd0, 12'd1, 32'd0);
    send_cmd(fcce_pkg::ACT_ALLOC, 12'd0, 12'd1, 32'd0);      // nothing left
    send_cmd(fcce_pkg::ACT_READ, 12'd3, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_EXTEND, 12'd2, 12'd4, 32'd0);
    send_cmd(fcce_pkg::ACT_FREE, 12'd2, 12'd0, 32'd0);
    write_cluster_count(13'd16);
    send_cmd(fcce_pkg::ACT_ALLOC, 12'd0, 12'd40, 32'd0);     // short of space
    send_cmd(fcce_pkg::ACT_EXTEND, 12'd2, 12'd1, 32'd0);
    send_cmd(fcce_pkg::ACT_FREE, 12'd2, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_WRITE, 12'd5, 12'd0, 32'd6);      // two-entry loop
    send_cmd(fcce_pkg::ACT_WRITE, 12'd6, 12'd0, 32'd5);
    send_cmd(fcce_pkg::ACT_EXTEND, 12'd5, 12'd1, 32'd0);
    send_cmd(fcce_pkg::ACT_WRITE, 12'd6, 12'd0, 32'd900);    // link leaves the table
    send_cmd(fcce_pkg::ACT_EXTEND, 12'd5, 12'd1, 32'd0);
    send_cmd(fcce_pkg::ACT_FREE, 12'd5, 12'd0, 32'd0);
    send_cmd(fcce_pkg::ACT_WRITE, 12'd0, 12'd0, fcce_pkg::EOC_MARK);
    send_cmd(fcce_pkg::ACT_EXTEND, 12'd9, 12'd1, 32'd0);     // free entry walks to cluster 0
  endtask

  function automatic logic [11:0] pick_index(int unsigned lim);
    if (chain_heads.size() != 0 && $urandom_range(0, 3) != 0)
      return 12'(chain_heads[$urandom_range(0, chain_heads.size() - 1)]);
    return 12'($urandom_range(0, lim - 1));
  endfunction

  // Mostly well-formed chain traffic with random content, some noise.
  task automatic test_random_traffic(int n_items);
    int unsigned lim, sel, k;
    logic [11:0] idx, cnt;
    logic [31:0] val;
    lim = active_limit();
    for (int i = 0; i < n_items; i++) begin
      steady = (i >= n_items / 4 && i < n_items / 4 + 15);
      if (i == n_items / 2) drain_results();       // let the output side empty out
      sel = $urandom_range(0, 99);
      idx = pick_index(lim);
      cnt = 12'($urandom_range(0, 6));
      if (sel < 28) begin
        if ($urandom_range(0, 30) == 0) cnt = 12'($urandom);
        send_cmd(fcce_pkg::ACT_ALLOC, 12'($urandom), cnt, $urandom);
      end else if (sel < 46) begin
        send_cmd(fcce_pkg::ACT_EXTEND, idx, cnt, $urandom);
      end else if (sel < 64) begin
        send_cmd(fcce_pkg::ACT_FREE, idx, 12'($urandom), $urandom);
        for (k = 0; k < chain_heads.size(); k++)
          if (chain_heads[k] == idx) begin
            chain_heads.delete(k);
            break;
          end
      end else if (sel < 78) begin
        send_cmd($urandom_range(0, 1) ? fcce_pkg::ACT_READ : fcce_pkg::ACT_NEXT, idx,
                 12'($urandom), $urandom);
      end else if (sel < 88) begin
        case ($urandom_range(0, 3))
          0: val = $urandom;
          1: val = $urandom_range(0, lim - 1);
          2: val = $urandom_range(32'h0FFF_FFF8, 32'hFFFF_FFFF);
          default: val = '0;
        endcase
        send_cmd(fcce_pkg::ACT_WRITE, 12'($urandom_range(0, lim - 1)), 12'($urandom), val);
      end else begin
        send_cmd(3'($urandom_range(0, 7)), 12'($urandom), 12'($urandom), $urandom);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    int unsigned settings[8] = '{16, 40, 3, 100, 4096, 64, 4095, 24};
    foreach (fat_mem[i]) fat_mem[i] = '0;
    clusters_cfg = 13'd4096;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_small_tables();
    foreach (settings[i]) begin
      write_cluster_count(13'(settings[i]));
      test_random_traffic(82);
    end
    drain_results();
    repeat (40) @(posedge clk);
    $display("Ran %0d commands, %0d results; reads %0d writes %0d allocs %0d extends %0d",
             cmds_sent, results_seen, action_hits[0] + action_hits[2], action_hits[1],
             action_hits[3], action_hits[4]);
    $display("frees %0d, unknown actions %0d, no-space results %0d, range errors %0d",
             action_hits[5], action_hits[6] + action_hits[7], nospace_seen, range_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: fat_cluster_chain_engine.f
rtl/fcce_pkg.sv
rtl/fcce_datapath.sv
rtl/fcce_ctrl.sv
rtl/fat_cluster_chain_engine.sv
rtl/fcce_checker.sv
bench/fat_cluster_chain_engine_tb.sv
